>>> src/crcv_pkg.sv
// Package for the CRC-checked record validator: record layout constants,
// register and cause codes, the verdict struct and the CRC-32 word update.
// No dependencies.
`timescale 1ns / 1ps

package crcv_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned VERSION_W = 16;
  localparam int unsigned INDEX_W = 4;

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [WORD_W-1:0] MARKER_RESET = 32'h53504C41;
  localparam logic [VERSION_W-1:0] VERSION_RESET = 16'd1;

  // Word positions inside the record
  localparam logic [INDEX_W-1:0] IDX_MARKER = 4'd0;
  localparam logic [INDEX_W-1:0] IDX_VERSION = 4'd1;
  localparam logic [INDEX_W-1:0] IDX_CRC = 4'd2;
  localparam logic [INDEX_W-1:0] IDX_LAT = 4'd3;
  localparam logic [INDEX_W-1:0] IDX_LON = 4'd4;
  localparam logic [INDEX_W-1:0] IDX_TIME = 4'd8;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 4'd15;

  typedef enum logic [0:0] {
    CFG_MARKER  = 1'b0,
    CFG_VERSION = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CAUSE_OK       = 3'd0,
    CAUSE_LENGTH   = 3'd1,
    CAUSE_HEADER   = 3'd2,
    CAUSE_CRC      = 3'd3,
    CAUSE_POSITION = 3'd4
  } fail_cause_e;

  typedef struct packed {
    logic        record_valid;
    fail_cause_e fail_cause;
    logic        time_known;
  } verdict_t;

  // Reflected CRC-32 over four bytes, least significant byte first.
  // Folding the whole word in at once equals the byte-by-byte update.
  function automatic logic [WORD_W-1:0] crc32_word(input logic [WORD_W-1:0] crc,
                                                   input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] c;
    c = crc ^ w;
    for (int b = 0; b < WORD_W; b++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

>>> src/crcv_if.sv
// Handshake interfaces for the record word stream and the verdict stream.
// Depends on nothing but the widths written here.
`timescale 1ns / 1ps

interface crcv_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] record_word;
  logic        last_word;

  modport source(output valid, output record_word, output last_word, input ready);
  modport sink(input valid, input record_word, input last_word, output ready);
endinterface

interface crcv_result_if;
  logic       valid;
  logic       ready;
  logic       record_valid;
  logic [2:0] fail_cause;
  logic       time_known;

  modport source(output valid, output record_valid, output fail_cause,
                 output time_known, input ready);
  modport sink(input valid, input record_valid, input fail_cause,
               input time_known, output ready);
endinterface

>>> src/crcv_input_reg.sv
// Input register for record words: holds one accepted word until the
// checker advances. Depends on crcv_pkg and crcv_word_if.
`timescale 1ns / 1ps

module crcv_input_reg
  import crcv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  crcv_word_if.sink         words,
  input  logic              advance,
  output logic              held_valid,
  output logic [WORD_W-1:0] held_word,
  output logic              held_last
);

  // Take a new word whenever the register is empty or drains this cycle
  assign words.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (words.valid && words.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      held_word <= words.record_word;
      held_last <= words.last_word;
    end
  end

endmodule

>>> src/crcv_record_check.sv
// Record state and checks: header compare, CRC-32 accumulation, position
// and time flags, and the verdict on the last word. Depends on crcv_pkg.
`timescale 1ns / 1ps

module crcv_record_check
  import crcv_pkg::*;
#(
  parameter int unsigned RECORD_WORDS = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [WORD_W-1:0]    word,
  input  logic                 last,
  input  logic [WORD_W-1:0]    expected_marker,
  input  logic [VERSION_W-1:0] expected_version,
  output verdict_t             verdict
);

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(RECORD_WORDS - 1);
  localparam logic [INDEX_W-1:0] WORDS_LIMIT = INDEX_W'(RECORD_WORDS);

  logic [INDEX_W-1:0] word_index;
  logic [WORD_W-1:0]  running_crc;
  logic [WORD_W-1:0]  held_crc;
  logic               header_good;
  logic               lat_is_zero;
  logic               lon_is_zero;
  logic               time_flag;

  logic [INDEX_W-1:0] word_index_next;
  logic [WORD_W-1:0]  running_crc_next;
  logic [WORD_W-1:0]  held_crc_next;
  logic               header_good_next;
  logic               lat_is_zero_next;
  logic               lon_is_zero_next;
  logic               time_flag_next;
  logic [WORD_W-1:0]  crc_update;
  fail_cause_e        cause;

  assign crc_update = crc32_word(running_crc, word);

  always_comb begin
    running_crc_next = running_crc;
    held_crc_next    = held_crc;
    header_good_next = header_good;
    lat_is_zero_next = lat_is_zero;
    lon_is_zero_next = lon_is_zero;
    time_flag_next   = time_flag;
    if (word_index < WORDS_LIMIT) begin
      case (word_index)
        IDX_MARKER: begin
          if (word != expected_marker) header_good_next = 1'b0;
        end
        IDX_VERSION: begin
          if (word[VERSION_W-1:0] != expected_version) header_good_next = 1'b0;
        end
        IDX_CRC: begin
          held_crc_next = word;
        end
        default: begin
          running_crc_next = crc_update;
          if (word_index == IDX_LAT) lat_is_zero_next = (word == '0);
          if (word_index == IDX_LON) lon_is_zero_next = (word == '0);
          if (word_index == IDX_TIME) time_flag_next = (word[15:8] != 8'd0);
        end
      endcase
    end
    word_index_next = (word_index == INDEX_MAX) ? word_index : word_index + 1'b1;

    // First failing check in priority order wins
    if (word_index != LAST_INDEX) begin
      cause = CAUSE_LENGTH;
    end else if (!header_good_next) begin
      cause = CAUSE_HEADER;
    end else if (~running_crc_next != held_crc_next) begin
      cause = CAUSE_CRC;
    end else if (lat_is_zero_next && lon_is_zero_next) begin
      cause = CAUSE_POSITION;
    end else begin
      cause = CAUSE_OK;
    end
    verdict.record_valid = (cause == CAUSE_OK);
    verdict.fail_cause   = cause;
    verdict.time_known   = (cause == CAUSE_OK) && time_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      word_index  <= '0;
      running_crc <= CRC_INIT;
      held_crc    <= '0;
      header_good <= 1'b1;
      lat_is_zero <= 1'b0;
      lon_is_zero <= 1'b0;
      time_flag   <= 1'b0;
    end else if (step) begin
      word_index  <= word_index_next;
      running_crc <= running_crc_next;
      held_crc    <= held_crc_next;
      header_good <= header_good_next;
      lat_is_zero <= lat_is_zero_next;
      lon_is_zero <= lon_is_zero_next;
      time_flag   <= time_flag_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last |=> word_index == '0 && running_crc == CRC_INIT && header_good)
    else $error("record state not cleared after last word");

  a_index_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(word_index))
    else $error("word index moved without a step");

  a_index_counts: assert property (@(posedge clk) disable iff (rst)
    step && !last && word_index != INDEX_MAX |=> word_index == $past(word_index) + 1'b1)
    else $error("word index did not advance");

endmodule

>>> src/crcv_result_reg.sv
// Output register for verdicts: holds one verdict until the sink takes it.
// Depends on crcv_pkg and crcv_result_if.
`timescale 1ns / 1ps

module crcv_result_reg
  import crcv_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  verdict_t       verdict,
  output logic           free,
  crcv_result_if.source  results
);

  verdict_t held;

  assign free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= verdict;
  end

  assign results.record_valid = held.record_valid;
  assign results.fail_cause   = held.fail_cause;
  assign results.time_known   = held.time_known;

endmodule

>>> src/crc_checked_record_validator_unit.sv
// Top level of the CRC-checked record validator: configuration registers,
// input register, record checker and verdict register.
// Depends on crcv_pkg, crcv_if, crcv_input_reg, crcv_record_check, crcv_result_reg.
//
//   Port      Kind          Payload                                   Moves on
//   words     sink          record_word[31:0], last_word              valid && ready
//   results   source        record_valid, fail_cause[2:0], time_known valid && ready
//   cfg_*     write port    cfg_index[0], cfg_wdata[31:0]             cfg_wr_en
//
// One record word per cycle sustained unless a closing word waits on a stalled
// results port; words are checked from the input register, verdicts registered.
// Throughput is set by the four-byte CRC-32 update, done combinationally.
// Reset (rst, synchronous) clears the record state, empties both registers
// and loads the default marker and version.
// A stalled results port holds a word that carries the last flag in the input
// register, and the input stalls behind it; words without the flag keep
// flowing into the checker.
`timescale 1ns / 1ps

module crc_checked_record_validator_unit
  import crcv_pkg::*;
#(
  parameter int unsigned RECORD_WORDS = 11
) (
  input  logic              clk,
  input  logic              rst,
  crcv_word_if.sink         words,
  crcv_result_if.source     results,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_wdata
);

  logic [WORD_W-1:0]    expected_marker;
  logic [VERSION_W-1:0] expected_version;

  logic              held_valid;
  logic [WORD_W-1:0] held_word;
  logic              held_last;
  logic              advance;
  logic              load;
  logic              free;
  verdict_t          verdict;

  // Configuration registers; the user must write them only while the block is idle, which it does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_marker  <= MARKER_RESET;
      expected_version <= VERSION_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_index))
        CFG_MARKER:  expected_marker  <= cfg_wdata;
        CFG_VERSION: expected_version <= cfg_wdata[VERSION_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held word unless it closes a record and the verdict slot is busy
  assign advance = held_valid && (!held_last || free);
  assign load    = advance && held_last;

  crcv_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .words      (words),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word),
    .held_last  (held_last)
  );

  crcv_record_check #(
    .RECORD_WORDS (RECORD_WORDS)
  ) u_record_check (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .word             (held_word),
    .last             (held_last),
    .expected_marker  (expected_marker),
    .expected_version (expected_version),
    .verdict          (verdict)
  );

  crcv_result_reg u_result_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .verdict (verdict),
    .free    (free),
    .results (results)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !results.valid || results.ready)
    else $error("verdict register overwritten while pending");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(load))
    else $error("verdict raised without a closing word");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !words.ready |-> held_valid && held_last && results.valid)
    else $error("input stalled with no pending verdict");

endmodule
